// File: src/lew_pkg.sv
// Package for the line editor with word wrap: shared widths, codes, types
// and the white space test. No dependencies; every other file imports it.
package lew_pkg;

   // Field widths of the channels and the configuration port.
   localparam int BYTE_W      = 8;
   localparam int ACTION_W    = 3;
   localparam int COUNT_W     = 6;
   localparam int CSR_INDEX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_CODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KILL_CODE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_ERASE_CODE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE        = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] ERASE_CODE_RESET      = 8'd127;
   localparam logic [BYTE_W-1:0] KILL_CODE_RESET       = 8'd21;
   localparam logic [BYTE_W-1:0] WORD_ERASE_CODE_RESET = 8'd23;
   localparam logic [BYTE_W-1:0] END_CODE_RESET        = 8'd4;

   // Fixed byte codes.
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [BYTE_W-1:0] PRINT_LO     = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI     = 8'h7E;
   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [BYTE_W-1:0] WHITE_LO     = 8'h09;
   localparam logic [BYTE_W-1:0] WHITE_HI     = 8'h0D;

   // Display actions of a result.
   typedef enum logic [ACTION_W-1:0] {
      ACT_ECHO    = 3'd0,
      ACT_ERASE   = 3'd1,
      ACT_NEWLINE = 3'd2,
      ACT_BELL    = 3'd3,
      ACT_END     = 3'd4
   } action_type;

   // Class of a received byte, in decision order (end test aside).
   typedef enum logic [2:0] {
      KIND_WORD_ERASE,
      KIND_NEWLINE,
      KIND_KILL,
      KIND_ERASE,
      KIND_TYPE,
      KIND_BELL
   } kind_type;

   // One classified byte as it travels through the command queue.
   typedef struct packed {
      logic              is_end;
      kind_type          kind;
      logic [BYTE_W-1:0] ch;
   } cmd_type;

   // Push side of the command queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   // Sequencer states of the back end.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WR_RD,
      ST_WR_CHK,
      ST_WR_ZERO_NL,
      ST_WR_ZERO_ECHO,
      ST_WR_ERASE,
      ST_WR_NL,
      ST_CP_RD,
      ST_CP_CHK,
      ST_WE_RD1,
      ST_WE_CHK1,
      ST_WE_RD2,
      ST_WE_CHK2,
      ST_WE_DONE
   } back_state_type;

   // Tab, line feed, vertical tab, form feed, carriage return or space.
   function automatic logic is_white(input logic [BYTE_W-1:0] c);
      return (c == SPACE_CODE) || ((c >= WHITE_LO) && (c <= WHITE_HI));
   endfunction

endpackage

// File: src/lew_req_if.sv
// Input channel of the line editor: one keyboard byte per transfer.
// Depends on lew_pkg for the byte width.
interface lew_req_if import lew_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// File: src/lew_rsp_if.sv
// Result channel of the line editor: one display action per transfer.
// Depends on lew_pkg for the field widths.
interface lew_rsp_if import lew_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   echo_byte;
   logic [COUNT_W-1:0]  erase_count;
   logic                last;

   modport source (output valid, output action, output echo_byte,
                   output erase_count, output last, input ready);
   modport sink   (input valid, input action, input echo_byte,
                   input erase_count, input last, output ready);
endinterface

// File: src/lew_front.sv
// Front end of the line editor: configuration registers and byte classifier.
// Depends on lew_pkg and lew_req_if; feeds the command queue.
module lew_front import lew_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   lew_req_if.sink                req,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   output cmd_push_type           push,
   input  logic                   push_ready
);

   logic [BYTE_W-1:0] erase_code_ff, erase_code_in;
   logic [BYTE_W-1:0] kill_code_ff, kill_code_in;
   logic [BYTE_W-1:0] word_erase_code_ff, word_erase_code_in;
   logic [BYTE_W-1:0] end_code_ff, end_code_in;
   kind_type          kind;

   // Register writes from the configuration port.
   always_comb begin
      erase_code_in      = erase_code_ff;
      kill_code_in       = kill_code_ff;
      word_erase_code_in = word_erase_code_ff;
      end_code_in        = end_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ERASE_CODE:      erase_code_in      = csr_wdata;
            CSR_KILL_CODE:       kill_code_in       = csr_wdata;
            CSR_WORD_ERASE_CODE: word_erase_code_in = csr_wdata;
            CSR_END_CODE:        end_code_in        = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_code_ff      <= ERASE_CODE_RESET;
         kill_code_ff       <= KILL_CODE_RESET;
         word_erase_code_ff <= WORD_ERASE_CODE_RESET;
         end_code_ff        <= END_CODE_RESET;
      end else begin
         erase_code_ff      <= erase_code_in;
         kill_code_ff       <= kill_code_in;
         word_erase_code_ff <= word_erase_code_in;
         end_code_ff        <= end_code_in;
      end
   end

   // Classify the byte; the first matching code wins.
   always_comb begin
      priority if (req.in_byte == word_erase_code_ff) begin
         kind = KIND_WORD_ERASE;
      end else if (req.in_byte == NEWLINE_CODE) begin
         kind = KIND_NEWLINE;
      end else if (req.in_byte == kill_code_ff) begin
         kind = KIND_KILL;
      end else if (req.in_byte == erase_code_ff) begin
         kind = KIND_ERASE;
      end else if ((req.in_byte >= PRINT_LO) && (req.in_byte <= PRINT_HI)) begin
         kind = KIND_TYPE;
      end else begin
         kind = KIND_BELL;
      end
   end

   // The end test needs the line length, so the back end resolves it.
   assign push.valid      = req.valid;
   assign push.cmd.is_end = (req.in_byte == end_code_ff);
   assign push.cmd.kind   = kind;
   assign push.cmd.ch     = req.in_byte;
   assign req.ready       = push_ready;

endmodule

// File: src/lew_cmd_fifo.sv
// Two-entry queue of classified commands between front and back end.
// Depends on lew_pkg for the command types.
module lew_cmd_fifo import lew_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_push_type push,
   output logic         push_ready,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  logic         pop_ready
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// File: src/lew_back.sv
// Back end of the line editor: line store, length, edit sequencer and the
// result register. Depends on lew_pkg and lew_rsp_if; fed by lew_cmd_fifo.
module lew_back import lew_pkg::*; #(
   parameter int LINE_LIMIT = 40
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   input  cmd_type pop_cmd,
   output logic    pop_ready,
   lew_rsp_if.source rsp
);

   localparam int CW = $clog2(LINE_LIMIT + 1);
   localparam logic [CW-1:0] LIMIT = CW'(LINE_LIMIT);
   localparam logic [CW-1:0] ONE   = CW'(1);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   cmd_type        cmd_ff, cmd_in;
   logic [BYTE_W-1:0] rdata_ff;
   logic [BYTE_W-1:0] line_store_mem [LINE_LIMIT + 1];

   logic              mem_we, mem_re;
   logic [CW-1:0]     mem_waddr, mem_raddr;
   logic [BYTE_W-1:0] mem_wdata;

   logic              emit, emit_ok, emit_last;
   action_type        emit_action;
   logic [BYTE_W-1:0] emit_byte;
   logic [CW-1:0]     emit_cnt;

   logic                out_valid_ff, out_valid_in;
   action_type          out_action_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [COUNT_W-1:0]  out_cnt_ff;
   logic                out_last_ff;

   // A result can be loaded when the register is empty or being drained.
   assign emit_ok   = !out_valid_ff || rsp.ready;
   assign pop_ready = (state_ff == ST_IDLE);

   // Sequencer: next state, memory access and result requests.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      cmd_in      = cmd_ff;
      mem_we      = 1'b0;
      mem_waddr   = count_ff;
      mem_wdata   = cmd_ff.ch;
      mem_re      = 1'b0;
      mem_raddr   = idx_ff;
      emit        = 1'b0;
      emit_action = ACT_ECHO;
      emit_byte   = '0;
      emit_cnt    = '0;
      emit_last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (cmd_ff.is_end && (count_ff == '0)) begin
               emit        = 1'b1;
               emit_action = ACT_END;
               emit_last   = 1'b1;
               if (emit_ok) state_in = ST_IDLE;
            end else begin
               unique case (cmd_ff.kind)
                  KIND_WORD_ERASE: begin
                     idx_in   = count_ff;
                     state_in = ST_WE_RD1;
                  end
                  KIND_NEWLINE: begin
                     emit        = 1'b1;
                     emit_action = ACT_NEWLINE;
                     emit_last   = 1'b1;
                     if (emit_ok) begin
                        count_in = '0;
                        state_in = ST_IDLE;
                     end
                  end
                  KIND_KILL: begin
                     if (count_ff != '0) begin
                        emit        = 1'b1;
                        emit_action = ACT_ERASE;
                        emit_cnt    = count_ff;
                        emit_last   = 1'b1;
                        if (emit_ok) begin
                           count_in = '0;
                           state_in = ST_IDLE;
                        end
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  KIND_ERASE: begin
                     if (count_ff != '0) begin
                        emit        = 1'b1;
                        emit_action = ACT_ERASE;
                        emit_cnt    = ONE;
                        emit_last   = 1'b1;
                        if (emit_ok) begin
                           count_in = count_ff - ONE;
                           state_in = ST_IDLE;
                        end
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  KIND_TYPE: begin
                     if (count_ff < LIMIT) begin
                        emit        = 1'b1;
                        emit_action = ACT_ECHO;
                        emit_byte   = cmd_ff.ch;
                        emit_last   = 1'b1;
                        if (emit_ok) begin
                           mem_we   = 1'b1;
                           count_in = count_ff + ONE;
                           state_in = ST_IDLE;
                        end
                     end else begin
                        // Full line: park the byte in the overflow slot and wrap.
                        mem_we    = 1'b1;
                        mem_waddr = LIMIT;
                        count_in  = LIMIT;
                        idx_in    = LIMIT;
                        state_in  = ST_WR_RD;
                     end
                  end
                  KIND_BELL: begin
                     emit        = 1'b1;
                     emit_action = ACT_BELL;
                     emit_last   = 1'b1;
                     if (emit_ok) state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // Wrap scan: look down from the overflow slot for white space.
         ST_WR_RD: begin
            if (idx_ff == '0) begin
               state_in = ST_WR_ZERO_NL;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_WR_CHK;
            end
         end
         ST_WR_CHK: begin
            if (is_white(rdata_ff)) begin
               state_in = ST_WR_ERASE;
            end else begin
               idx_in   = idx_ff - ONE;
               state_in = ST_WR_RD;
            end
         end
         // No space on the line: only the typed byte moves.
         ST_WR_ZERO_NL: begin
            emit        = 1'b1;
            emit_action = ACT_NEWLINE;
            if (emit_ok) state_in = ST_WR_ZERO_ECHO;
         end
         ST_WR_ZERO_ECHO: begin
            emit        = 1'b1;
            emit_action = ACT_ECHO;
            emit_byte   = cmd_ff.ch;
            emit_last   = 1'b1;
            if (emit_ok) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               count_in  = ONE;
               state_in  = ST_IDLE;
            end
         end
         // Rub out the tail word, then start the new line.
         ST_WR_ERASE: begin
            if (idx_ff == LIMIT) begin
               state_in = ST_WR_NL;
            end else begin
               emit        = 1'b1;
               emit_action = ACT_ERASE;
               emit_cnt    = LIMIT - idx_ff;
               if (emit_ok) state_in = ST_WR_NL;
            end
         end
         ST_WR_NL: begin
            emit        = 1'b1;
            emit_action = ACT_NEWLINE;
            emit_last   = (idx_ff == LIMIT);
            if (emit_ok) begin
               count_in = '0;
               if (idx_ff == LIMIT) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ONE;
                  state_in = ST_CP_RD;
               end
            end
         end
         // Move the tail word to the front of the line, echoing each byte.
         ST_CP_RD: begin
            mem_re   = 1'b1;
            state_in = ST_CP_CHK;
         end
         ST_CP_CHK: begin
            emit        = 1'b1;
            emit_action = ACT_ECHO;
            emit_byte   = rdata_ff;
            emit_last   = (idx_ff == LIMIT);
            if (emit_ok) begin
               mem_we    = 1'b1;
               mem_wdata = rdata_ff;
               count_in  = count_ff + ONE;
               if (idx_ff == LIMIT) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ONE;
                  state_in = ST_CP_RD;
               end
            end
         end
         // Word erase: skip trailing white space, then the word itself.
         ST_WE_RD1: begin
            if (idx_ff == '0) begin
               state_in = ST_WE_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff - ONE;
               state_in  = ST_WE_CHK1;
            end
         end
         ST_WE_CHK1: begin
            if (is_white(rdata_ff)) begin
               idx_in   = idx_ff - ONE;
               state_in = ST_WE_RD1;
            end else begin
               // The byte just read is the first one of the word phase.
               state_in = ST_WE_CHK2;
            end
         end
         ST_WE_RD2: begin
            if (idx_ff == '0) begin
               state_in = ST_WE_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff - ONE;
               state_in  = ST_WE_CHK2;
            end
         end
         ST_WE_CHK2: begin
            if (!is_white(rdata_ff)) begin
               idx_in   = idx_ff - ONE;
               state_in = ST_WE_RD2;
            end else begin
               state_in = ST_WE_DONE;
            end
         end
         ST_WE_DONE: begin
            if (idx_ff != count_ff) begin
               emit        = 1'b1;
               emit_action = ACT_ERASE;
               emit_cnt    = count_ff - idx_ff;
               emit_last   = 1'b1;
               if (emit_ok) begin
                  count_in = idx_ff;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current command.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
   end

   // Line store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= line_store_mem[mem_raddr];
      end
   end

   // Result register that decouples the sequencer from the sink.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (emit && emit_ok) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && emit_ok) begin
         out_action_ff <= emit_action;
         out_byte_ff   <= emit_byte;
         out_cnt_ff    <= COUNT_W'(emit_cnt);
         out_last_ff   <= emit_last;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.action      = out_action_ff;
   assign rsp.echo_byte   = out_byte_ff;
   assign rsp.erase_count = out_cnt_ff;
   assign rsp.last        = out_last_ff;

endmodule

// File: src/line_editor_with_word_wrap_unit.sv
// Top level of the line editor with word wrap: front end, command queue and
// back end. Depends on lew_pkg, lew_req_if, lew_rsp_if and the three parts.

// Terminal line editor. Each keyboard byte taken on req becomes one to
// LINE_LIMIT+1 display actions on rsp (echo, erase N, newline, bell, session
// end); the final action of a byte has last set, and a byte with nothing to
// erase gives none. The front end classifies a byte in the cycle it is
// transferred and a two-entry queue holds up to two bytes ahead of the back
// end. The back end takes one byte at a time. A word erase walks back over
// the characters it removes, and a wrap scans down from the end of the line
// for white space and then moves each character after it to the new line;
// these walks are set by the single read port of the line store and its
// registered read data. A result waiting on rsp holds the back end only when
// it has another result to present. The line store needs no clearing after
// reset; only written entries are ever read.
module line_editor_with_word_wrap_unit import lew_pkg::*; #(
   parameter int LINE_LIMIT = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   lew_req_if.sink                req,
   lew_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   cmd_push_type push;
   logic         push_ready;
   logic         pop_valid;
   logic         pop_ready;
   cmd_type      pop_cmd;

   // Classification and configuration.
   lew_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_ready (push_ready)
   );

   // Queue between the two halves.
   lew_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // Line store and edit sequencer.
   lew_back #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule

// File: verif/tb_line_editor_with_word_wrap_unit.sv
// Self-checking testbench for line_editor_with_word_wrap_unit: directed edits, code
// priorities, word wrap shapes and random typing against an in-bench line model.
// Depends on lew_pkg, lew_req_if, lew_rsp_if and the line editor RTL.
module tb_line_editor_with_word_wrap_unit import lew_pkg::*; ();

   localparam int LINE_LIMIT    = 40;
   localparam int CLOCK_PERIOD  = 20;
   localparam int SETTLE_CYCLES = 4 * (2 * LINE_LIMIT + 6);
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int MAX_PRINTED   = 30;

   typedef logic [BYTE_W-1:0] key_byte_type;

   // One display action as the editor should present it.
   typedef struct packed {
      action_type         action;
      logic [BYTE_W-1:0]  echo_byte;
      logic [COUNT_W-1:0] erase_count;
      logic               last;
   } display_action_type;

   // Patterns the display side uses to hold off results.
   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_STALLS,
      RDY_PERIODIC
   } ready_pattern_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_wdata;

   lew_req_if req_ch ();
   lew_rsp_if rsp_ch ();

   // Editor model state and its copy of the code registers.
   key_byte_type line_buf [0:LINE_LIMIT];
   int           line_len;
   key_byte_type erase_reg;
   key_byte_type kill_reg;
   key_byte_type word_erase_reg;
   key_byte_type end_reg;

   // Actions of the keystroke being modeled, then the queue of pending actions.
   display_action_type step_actions [0:LINE_LIMIT];
   int                 step_n;
   display_action_type expected_q [$];
   display_action_type want;

   // Run statistics and error count.
   int mismatch_count;
   int bytes_sent;
   int keystrokes_with_output;
   int actions_checked;
   int wrap_count;
   int bare_wrap_count;
   int longest_burst;
   int settings_count;

   // Sender burst state and receiver hold-off state.
   int                burst_left;
   ready_pattern_type ready_mode;
   int                stall_left;
   int                cycle_n;

   line_editor_with_word_wrap_unit #(
      .LINE_LIMIT(LINE_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the editor hangs.
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d display actions still outstanding", expected_q.size());
      $display("status: fail");
      $finish;
   end

   // Counts a mismatch and prints the first few of them.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   function automatic logic is_blank(input key_byte_type c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   task automatic add_action(input action_type a, input key_byte_type b, input int n);
      step_actions[step_n] = '{a, b, n[COUNT_W-1:0], 1'b0};
      step_n++;
   endtask

   // Wraps the last word of a full line once the overflow slot holds a byte.
   task automatic wrap_full_line();
      int p;
      int k;
      p = LINE_LIMIT;
      while (p != 0 && !is_blank(line_buf[p])) p--;
      wrap_count++;
      if (p == 0) begin
         // No space to break at: only the typed byte moves down.
         bare_wrap_count++;
         add_action(ACT_NEWLINE, '0, 0);
         add_action(ACT_ECHO, line_buf[LINE_LIMIT], 0);
         line_buf[0] = line_buf[LINE_LIMIT];
         line_len = 1;
      end else begin
         if (LINE_LIMIT - p > 0) begin
            add_action(ACT_ERASE, '0, LINE_LIMIT - p);
         end
         add_action(ACT_NEWLINE, '0, 0);
         line_len = 0;
         for (k = p + 1; k <= LINE_LIMIT; k++) begin
            add_action(ACT_ECHO, line_buf[k], 0);
            line_buf[line_len] = line_buf[k];
            line_len++;
         end
      end
   endtask

   // Works out the display actions of one accepted keystroke and queues them.
   task automatic predict_keystroke(input key_byte_type c);
      int n;
      display_action_type act;
      step_n = 0;
      if (c == end_reg && line_len == 0) begin
         add_action(ACT_END, '0, 0);
      end else if (c == word_erase_reg) begin
         // Trailing spaces first, then the word before them.
         n = line_len;
         while (n > 0 && is_blank(line_buf[n-1])) n--;
         while (n > 0 && !is_blank(line_buf[n-1])) n--;
         if (n != line_len) begin
            add_action(ACT_ERASE, '0, line_len - n);
         end
         line_len = n;
      end else if (c == NEWLINE_CODE) begin
         line_len = 0;
         add_action(ACT_NEWLINE, '0, 0);
      end else if (c == kill_reg) begin
         if (line_len > 0) begin
            add_action(ACT_ERASE, '0, line_len);
         end
         line_len = 0;
      end else if (c == erase_reg) begin
         if (line_len > 0) begin
            add_action(ACT_ERASE, '0, 1);
            line_len--;
         end
      end else if (c >= PRINT_LO && c <= PRINT_HI) begin
         if (line_len >= LINE_LIMIT) begin
            line_len = LINE_LIMIT;
            line_buf[LINE_LIMIT] = c;
            wrap_full_line();
         end else begin
            line_buf[line_len] = c;
            line_len++;
            add_action(ACT_ECHO, c, 0);
         end
      end else begin
         add_action(ACT_BELL, '0, 0);
      end

      // The final action of the keystroke carries the last flag.
      for (int i = 0; i < step_n; i++) begin
         act = step_actions[i];
         act.last = (i == step_n - 1);
         expected_q.push_back(act);
      end
      if (step_n > 0) begin
         keystrokes_with_output++;
      end
      if (step_n > longest_burst) begin
         longest_burst = step_n;
      end
   endtask

   // Sends one keystroke; the sender works in bursts with random gaps.
   task automatic send_byte(input key_byte_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= c;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_keystroke(c);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Random printable byte that is neither a space nor one of the edit codes.
   function automatic key_byte_type pick_text_char();
      key_byte_type c;
      c = key_byte_type'($urandom_range(PRINT_LO + 1, PRINT_HI));
      while (c == erase_reg || c == kill_reg || c == word_erase_reg || c == end_reg) begin
         c = key_byte_type'($urandom_range(PRINT_LO + 1, PRINT_HI));
      end
      return c;
   endfunction

   task automatic type_chars(input int count);
      repeat (count) send_byte(pick_text_char());
   endtask

   // Stops sending, waits for every pending action, then lets the editor settle.
   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all four edit codes back to back; only called while idle.
   task automatic write_edit_codes(input key_byte_type erase_c, input key_byte_type kill_c,
                                   input key_byte_type word_c, input key_byte_type end_c);
      csr_we    <= 1'b1;
      csr_index <= CSR_ERASE_CODE;
      csr_wdata <= erase_c;
      @(negedge clock);
      csr_index <= CSR_KILL_CODE;
      csr_wdata <= kill_c;
      @(negedge clock);
      csr_index <= CSR_WORD_ERASE_CODE;
      csr_wdata <= word_c;
      @(negedge clock);
      csr_index <= CSR_END_CODE;
      csr_wdata <= end_c;
      @(negedge clock);
      csr_we <= 1'b0;
      erase_reg      = erase_c;
      kill_reg       = kill_c;
      word_erase_reg = word_c;
      end_reg        = end_c;
      settings_count++;
   endtask

   // Every edit under the reset codes, including the ones with nothing to erase.
   task automatic test_basic_edits();
      key_byte_type keys [18];
      keys = '{END_CODE_RESET, 8'h00, NEWLINE_CODE, ERASE_CODE_RESET, KILL_CODE_RESET,
               WORD_ERASE_CODE_RESET, SPACE_CODE, WORD_ERASE_CODE_RESET, "a", PRINT_HI,
               SPACE_CODE, "b", END_CODE_RESET, ERASE_CODE_RESET, WORD_ERASE_CODE_RESET,
               "c", KILL_CODE_RESET, 8'hFF};
      foreach (keys[i]) send_byte(keys[i]);
   endtask

   // Bytes that match several codes take the first in decision order.
   task automatic test_code_priority();
      key_byte_type keys_a [7];
      key_byte_type keys_b [7];
      keys_a = '{END_CODE_RESET, "k", SPACE_CODE, "k", END_CODE_RESET, "k", NEWLINE_CODE};
      keys_b = '{PRINT_HI, "a", PRINT_HI, NEWLINE_CODE, 8'h00, "b", 8'hFF};
      wait_for_idle();
      // Space erases, newline shadows kill, word erase shares the end byte.
      write_edit_codes(SPACE_CODE, NEWLINE_CODE, END_CODE_RESET, END_CODE_RESET);
      foreach (keys_a[i]) send_byte(keys_a[i]);
      wait_for_idle();
      // Extreme code values; word erase shadows newline, tilde ends a session.
      write_edit_codes(8'h00, 8'hFF, NEWLINE_CODE, PRINT_HI);
      foreach (keys_b[i]) send_byte(keys_b[i]);
   endtask

   // Wrap shapes with random text: longest result run, break at the last
   // position, a space as the overflow byte, and a space only at position 0.
   task automatic test_word_wrap();
      wait_for_idle();
      write_edit_codes(ERASE_CODE_RESET, KILL_CODE_RESET, WORD_ERASE_CODE_RESET,
                       END_CODE_RESET);
      send_byte(NEWLINE_CODE);
      type_chars(1);
      send_byte(SPACE_CODE);
      type_chars(LINE_LIMIT - 2);
      type_chars(1);
      send_byte(SPACE_CODE);
      type_chars(1);
      type_chars(LINE_LIMIT - 1);
      send_byte(SPACE_CODE);
      send_byte(SPACE_CODE);
      type_chars(LINE_LIMIT - 1);
      type_chars(1);
   endtask

   // Mostly words and spaces, with edits, control bytes and high bytes mixed in.
   task automatic test_random_editing(input int target);
      int start;
      int pick;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            type_chars($urandom_range(1, 6));
            send_byte(SPACE_CODE);
         end else if (pick < 60) begin
            send_byte(erase_reg);
         end else if (pick < 66) begin
            send_byte(word_erase_reg);
         end else if (pick < 70) begin
            send_byte(kill_reg);
         end else if (pick < 75) begin
            send_byte(NEWLINE_CODE);
         end else if (pick < 79) begin
            send_byte(end_reg);
         end else if (pick < 87) begin
            send_byte(key_byte_type'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            send_byte(key_byte_type'($urandom_range(0, PRINT_LO - 1)));
         end else begin
            send_byte(key_byte_type'($urandom_range(8'h80, 8'hFF)));
         end
      end
   endtask

   // Display side: ready follows a hold-off pattern that is picked at random.
   always @(negedge clock) begin
      cycle_n++;
      if (cycle_n % 200 == 0) begin
         ready_mode = ready_pattern_type'($urandom_range(0, 3));
      end
      case (ready_mode)
         RDY_ALWAYS: begin
            rsp_ch.ready <= 1'b1;
         end
         RDY_COIN: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end
         RDY_STALLS: begin
            if (stall_left > 0) begin
               rsp_ch.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ch.ready <= 1'b1;
               stall_left = $urandom_range(0, 7);
            end
         end
         default: begin
            rsp_ch.ready <= (cycle_n % 5) != 0;
         end
      endcase
   end

   // Each result transfer is compared with the oldest pending action.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, action %0d", rsp_ch.action));
         end else begin
            want = expected_q.pop_front();
            actions_checked++;
            if (rsp_ch.action !== want.action) begin
               report_mismatch($sformatf("action %0d, expected %0d", rsp_ch.action,
                                         want.action));
            end
            if (rsp_ch.echo_byte !== want.echo_byte) begin
               report_mismatch($sformatf("echo_byte %h, expected %h", rsp_ch.echo_byte,
                                         want.echo_byte));
            end
            if (rsp_ch.erase_count !== want.erase_count) begin
               report_mismatch($sformatf("erase_count %0d, expected %0d",
                                         rsp_ch.erase_count, want.erase_count));
            end
            if (rsp_ch.last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_ch.last, want.last));
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      ready_mode     = RDY_ALWAYS;
      stall_left     = 0;
      cycle_n        = 0;
      burst_left     = 0;
      line_len       = 0;
      erase_reg      = ERASE_CODE_RESET;
      kill_reg       = KILL_CODE_RESET;
      word_erase_reg = WORD_ERASE_CODE_RESET;
      end_reg        = END_CODE_RESET;
      settings_count = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_edits();
      test_code_priority();
      test_word_wrap();
      test_random_editing(5);

      // Control codes at the extremes, then two fully random settings.
      wait_for_idle();
      write_edit_codes(8'h08, 8'hFF, 8'h00, 8'h1A);
      test_random_editing(5);
      wait_for_idle();
      write_edit_codes(key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)));
      test_random_editing(5);
      wait_for_idle();
      write_edit_codes(key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)),
                       key_byte_type'($urandom_range(0, 255)));
      test_random_editing(5);

      wait_for_idle();
      $display("sent %0d keystrokes (%0d with output) under %0d code settings, %0d actions",
               bytes_sent, keystrokes_with_output, settings_count, actions_checked);
      $display("saw %0d line wraps (%0d with no space), up to %0d actions per keystroke",
               wrap_count, bare_wrap_count, longest_burst);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/lew_pkg.sv
src/lew_req_if.sv
src/lew_rsp_if.sv
src/lew_front.sv
src/lew_cmd_fifo.sv
src/lew_back.sv
src/line_editor_with_word_wrap_unit.sv
verif/tb_line_editor_with_word_wrap_unit.sv
